>>> sv/ps2kst_pkg.sv
// Package: shared types, constants and helpers of the PS/2 key state table.
`timescale 1ns / 1ps

package ps2kst_pkg;

   localparam int NUM_KEYS   = 256;
   localparam int KEY_IDX_W  = $clog2(NUM_KEYS);
   localparam int CODE_W     = 8;
   localparam int FUNC_W     = 2;
   localparam int STATE_W    = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;

   localparam logic [CODE_W-1:0] CODE_EXTENDED = 8'he0;
   localparam logic [CODE_W-1:0] CODE_RELEASE  = 8'hf0;
   localparam logic [CODE_W-1:0] CODE_TOP_BIT  = 8'h80;

   // Input function codes.
   localparam logic [FUNC_W-1:0] FUNC_SCAN  = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_TEST  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_CLEAR = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_SET1_MODE      = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_FORWARD_ENABLE = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ARCADE_ONLY    = 2'd2;

   // Key table entry bits.
   localparam logic [STATE_W-1:0] STATE_HELD   = 2'b01;
   localparam logic [STATE_W-1:0] STATE_STICKY = 2'b10;
   localparam logic [STATE_W-1:0] STATE_PRESS  = 2'b11;

   typedef enum logic [1:0] {
      OP_NONE,
      OP_TEST,
      OP_PRESS,
      OP_RELEASE
   } op_type;

   typedef struct packed {
      logic set1_mode;
      logic forward_enable;
      logic arcade_only;
   } cfg_type;

   typedef struct packed {
      op_type                op;
      logic                  clear;
      logic [KEY_IDX_W-1:0]  idx;
      logic                  fwd_valid;
      logic [CODE_W-1:0]     fwd_key;
      logic                  fwd_extended;
      logic                  fwd_release;
   } dec_type;

   typedef struct packed {
      logic                  fwd_valid;
      logic [CODE_W-1:0]     fwd_key;
      logic                  fwd_extended;
      logic                  fwd_release;
      logic [STATE_W-1:0]    key_state;
   } rsp_type;

   function automatic logic is_arcade(input logic [CODE_W-1:0] k);
      return k inside {8'h16, 8'h1e, 8'h26, 8'h25, 8'h2e, 8'h36, 8'h3d, 8'h3e};
   endfunction

endpackage

>>> sv/ps2kst_decode.sv
// Scan byte decoder: prefix tracking and key event formation.
`timescale 1ns / 1ps

module ps2kst_decode (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          accept,
   input  ps2kst_pkg::cfg_type           cfg,
   input  logic [ps2kst_pkg::FUNC_W-1:0] func,
   input  logic [ps2kst_pkg::CODE_W-1:0] code,
   input  logic                          block_forward,
   output ps2kst_pkg::dec_type           dec
);
   import ps2kst_pkg::*;

   logic              ext_pending_ff;
   logic              ext_pending_in;
   logic              release_pending_ff;
   logic              release_pending_in;
   logic [CODE_W-1:0] key;
   logic              rel;
   logic              complete;

   always_comb begin
      dec                = '0;
      dec.op             = OP_NONE;
      ext_pending_in     = ext_pending_ff;
      release_pending_in = release_pending_ff;
      key                = code;
      rel                = release_pending_ff;
      complete           = 1'b0;
      case (func)
         FUNC_TEST: begin
            dec.op  = OP_TEST;
            dec.idx = code[KEY_IDX_W-1:0];
         end
         FUNC_CLEAR: begin
            dec.clear = 1'b1;
         end
         FUNC_SCAN: begin
            if (code == CODE_EXTENDED) begin
               ext_pending_in = 1'b1;
            end else if (cfg.set1_mode) begin
               // Set 1 carries the release in the top bit of the code itself.
               if ((code & CODE_TOP_BIT) != '0) begin
                  rel = 1'b1;
                  key = code & ~CODE_TOP_BIT;
               end
               complete = 1'b1;
            end else if (code == CODE_RELEASE) begin
               release_pending_in = 1'b1;
            end else begin
               complete = 1'b1;
            end
         end
         default: begin
         end
      endcase

      if (complete) begin
         dec.op  = rel ? OP_RELEASE : OP_PRESS;
         dec.idx = ext_pending_ff ? KEY_IDX_W'(key | CODE_TOP_BIT) : KEY_IDX_W'(key);
         if (cfg.forward_enable && !block_forward && (!cfg.arcade_only || is_arcade(key))) begin
            dec.fwd_valid    = 1'b1;
            dec.fwd_key      = key;
            dec.fwd_extended = ext_pending_ff;
            dec.fwd_release  = rel;
         end
         ext_pending_in     = 1'b0;
         release_pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ext_pending_ff     <= 1'b0;
         release_pending_ff <= 1'b0;
      end else if (accept) begin
         ext_pending_ff     <= ext_pending_in;
         release_pending_ff <= release_pending_in;
      end
   end

endmodule

>>> sv/ps2kst_table.sv
// Key state memory with per-entry valid bits and read-modify-write stage.
`timescale 1ns / 1ps

module ps2kst_table (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic                retire,
   input  ps2kst_pkg::dec_type dec,
   output logic                s1_valid,
   output ps2kst_pkg::rsp_type result
);
   import ps2kst_pkg::*;

   logic [STATE_W-1:0]   key_mem [NUM_KEYS];
   logic [NUM_KEYS-1:0]  valid_ff;
   logic [STATE_W-1:0]   mem_rd_ff;
   logic                 vld_rd_ff;
   logic                 s1_valid_ff;
   dec_type              s1_ff;
   logic [STATE_W-1:0]   entry;
   logic [STATE_W-1:0]   wr_data;
   logic                 wr_en;

   // Entries never written since the last clear read as zero.
   assign entry = vld_rd_ff ? mem_rd_ff : '0;

   always_comb begin
      wr_data = entry;
      case (s1_ff.op)
         OP_TEST:    wr_data = entry & STATE_HELD;
         OP_PRESS:   wr_data = STATE_PRESS;
         OP_RELEASE: wr_data = entry & STATE_STICKY;
         default:    wr_data = entry;
      endcase
   end

   assign wr_en = retire && (s1_ff.op != OP_NONE);

   always_comb begin
      result              = '0;
      result.fwd_valid    = s1_ff.fwd_valid;
      result.fwd_key      = s1_ff.fwd_key;
      result.fwd_extended = s1_ff.fwd_extended;
      result.fwd_release  = s1_ff.fwd_release;
      result.key_state    = (s1_ff.op == OP_TEST) ? entry : '0;
   end

   assign s1_valid = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (accept) begin
         mem_rd_ff <= key_mem[dec.idx];
         vld_rd_ff <= valid_ff[dec.idx];
         s1_ff     <= dec;
      end
      if (wr_en) begin
         key_mem[s1_ff.idx] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         s1_valid_ff <= 1'b0;
      end else begin
         if (accept && dec.clear) begin
            valid_ff <= '0;
         end else if (wr_en) begin
            valid_ff[s1_ff.idx] <= 1'b1;
         end
         if (accept) begin
            s1_valid_ff <= 1'b1;
         end else if (retire) begin
            s1_valid_ff <= 1'b0;
         end
      end
   end

   // No item, a clear included, must ever be accepted while a write-back is pending.
   assert property (@(posedge clock) disable iff (reset) accept |-> !s1_valid_ff)
      else $error("item accepted while table stage busy");
   assert property (@(posedge clock) disable iff (reset)
                    (accept && dec.clear) |=> (valid_ff == '0))
      else $error("table clear did not drop all valid bits");
   assert property (@(posedge clock) disable iff (reset)
                    wr_en |=> valid_ff[$past(s1_ff.idx)])
      else $error("written entry not marked valid");

endmodule

>>> sv/ps2_scancode_key_state_table.sv
// Top level: PS/2 scan-code decoder with a 256-entry key state table.
`timescale 1ns / 1ps
// An accepted item is read from the key table into the table stage, then loaded into the output
// register when it retires; an output stall delays that. No new item enters until the last retires.
// The memory read at acceptance and the write-back at retirement are interlocked, not overlapped.
// Reset (synchronous, active high) clears prefix flags and all key valid bits, and returns the
// configuration to its defaults; the table then reads as all zero, with no clearing pass.

module ps2_scancode_key_state_table (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [ps2kst_pkg::FUNC_W-1:0]     req_func,
   input  logic [ps2kst_pkg::CODE_W-1:0]     req_code,
   input  logic                              req_block_forward,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic                              rsp_fwd_valid,
   output logic [ps2kst_pkg::CODE_W-1:0]     rsp_fwd_key,
   output logic                              rsp_fwd_extended,
   output logic                              rsp_fwd_release,
   output logic [ps2kst_pkg::STATE_W-1:0]    rsp_key_state,
   input  logic                              csr_write_enable,
   input  logic [ps2kst_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ps2kst_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import ps2kst_pkg::*;

   cfg_type cfg_ff;
   dec_type dec;
   rsp_type result;
   rsp_type rsp_ff;
   logic    rsp_valid_ff;
   logic    s1_valid;
   logic    accept;
   logic    retire;

   // The table stage holds one item at a time; the output register parts the two sides,
   // so a new item may enter while the previous result still waits to be taken.
   assign req_stall = s1_valid;
   assign accept    = req_valid && !req_stall;
   assign retire    = s1_valid && (!rsp_valid_ff || !rsp_stall);

   // Configuration writes are plain register updates; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.set1_mode      <= 1'b0;
         cfg_ff.forward_enable <= 1'b1;
         cfg_ff.arcade_only    <= 1'b0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_SET1_MODE:      cfg_ff.set1_mode      <= csr_write_data[0];
            CSR_FORWARD_ENABLE: cfg_ff.forward_enable <= csr_write_data[0];
            CSR_ARCADE_ONLY:    cfg_ff.arcade_only    <= csr_write_data[0];
            default: begin
            end
         endcase
      end
   end

   ps2kst_decode u_decode (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .cfg           (cfg_ff),
      .func          (req_func),
      .code          (req_code),
      .block_forward (req_block_forward),
      .dec           (dec)
   );

   ps2kst_table u_table (
      .clock    (clock),
      .reset    (reset),
      .accept   (accept),
      .retire   (retire),
      .dec      (dec),
      .s1_valid (s1_valid),
      .result   (result)
   );

   // Output register: loaded when the table stage retires, held while stalled.
   always_ff @(posedge clock) begin
      if (retire) begin
         rsp_ff <= result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (retire) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_fwd_valid    = rsp_ff.fwd_valid;
   assign rsp_fwd_key      = rsp_ff.fwd_key;
   assign rsp_fwd_extended = rsp_ff.fwd_extended;
   assign rsp_fwd_release  = rsp_ff.fwd_release;
   assign rsp_key_state    = rsp_ff.key_state;

   assert property (@(posedge clock) disable iff (reset) accept |=> s1_valid)
      else $error("accepted item did not reach the table stage");
   assert property (@(posedge clock) disable iff (reset) retire |=> rsp_valid_ff)
      else $error("retired item did not reach the output register");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && !rsp_ff.fwd_valid) |->
                    (rsp_ff.fwd_key == '0 && !rsp_ff.fwd_extended && !rsp_ff.fwd_release))
      else $error("forward fields set without a forwarded event");
   assert property (@(posedge clock) disable iff (reset)
                    (rsp_valid_ff && rsp_ff.key_state != '0) |-> !rsp_ff.fwd_valid)
      else $error("test result and forwarded event in the same item");

endmodule
